// File: hw/rtl/lmsp_pkg.sv
`default_nettype none

package lmsp_pkg;

    localparam int ROWS   = 6;
    localparam int LVL_W  = 8;
    localparam int COL_W  = 17;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [LVL_W-1:0] CMP_LOW      = 8'd25;
    localparam logic [LVL_W-1:0] CMP_HIGH     = 8'd230;
    localparam logic [LVL_W-1:0] BRIGHT_RESET = 8'd127;

    typedef struct packed {
        logic cnt_clr;
        logic cnt_inc;
        logic mem_zero;
        logic tick;
        logic pix_wr;
        logic rd_req;
        logic rd_load;
        logic adv;
        logic fetch;
        logic show;
        logic copy;
        logic clear_back;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic wrap;
        logic store_last;
        logic copy_last;
        logic fetch_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: hw/rtl/led_matrix_scan_pwm_top.sv
`default_nettype none

// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata col_x,row_y,pixel_level; tuser func
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata row_drive,column_drive,read_level
// cfg       in   i_cfg_valid/o_cfg_ready           global_brightness
//
// Tick, pixel write, unused codes: result loaded from idle. Pixel read: registered RAM read.
// Tick that wraps the timer: advance, front-store reads of all 6 rows, row update.
// Update copies the back store to the front, clear zeroes the back; one store entry per cycle.
// After reset a pass over all COLUMNS*6 entries zeroes both stores; no item is taken then.
// One item at a time; the next item is taken once the output register is free or being read.
module led_matrix_scan_pwm_top #(
    parameter int COLUMNS    = 17,
    parameter int PWM_LEVELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // col_x[7:0], row_y[15:8], pixel_level[23:16]
    input  wire logic [2:0]  i_s_axis_tuser,   // func[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // row_drive[7:0], column_drive[24:8],
                                               // read_level[32:25], zero[39:33]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int LW  = lmsp_pkg::LVL_W;
    localparam int CDW = lmsp_pkg::COL_W;
    localparam int PAD = 40 - (2 * LW + CDW);

    lmsp_pkg::t_cmd  w_cmd;
    lmsp_pkg::t_stat w_stat;
    logic [LW-1:0]   w_row_drive;
    logic [CDW-1:0]  w_col_drive;
    logic [LW-1:0]   w_read_level;
    logic            s_accept;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_axis_tvalid && o_s_axis_tready;

    lmsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_func  (i_s_axis_tuser),
        .o_ready (o_s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lmsp_dp #(
        .COLUMNS    (COLUMNS),
        .PWM_LEVELS (PWM_LEVELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_col_x        (i_s_axis_tdata[7:0]),
        .i_row_y        (i_s_axis_tdata[15:8]),
        .i_level        (i_s_axis_tdata[23:16]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_row_drive    (w_row_drive),
        .o_column_drive (w_col_drive),
        .o_read_level   (w_read_level)
    );

    assign o_m_axis_tdata = {PAD'(0), w_read_level, w_col_drive, w_row_drive};

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("item taken while result register is occupied");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over an unread result");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == lmsp_pkg::FUNC_TICK && !w_stat.wrap)
        |=> o_m_axis_tvalid)
        else $error("plain tick gave no result in the next cycle");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_col_drive >> COLUMNS) == '0))
        else $error("column drive set beyond the last column");

endmodule

`default_nettype wire

// File: hw/rtl/lmsp_ram.sv
`default_nettype none

module lmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 102
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/lmsp_ctrl.sv
`default_nettype none

module lmsp_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [lmsp_pkg::FUNC_W-1:0]    i_func,
    output logic                                o_ready,
    input  wire lmsp_pkg::t_stat                i_stat,
    output lmsp_pkg::t_cmd                      o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_ADV   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_SHOW  = 3'd5;
    localparam logic [2:0] S_COPY  = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                // zero both stores after reset
                o_cmd.mem_zero = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_stat.store_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = i_stat.out_free;
                if (i_valid && i_stat.out_free) begin
                    unique case (i_func)
                        lmsp_pkg::FUNC_TICK: begin
                            o_cmd.tick = 1'b1;
                            if (i_stat.wrap) begin
                                n_state = S_ADV;
                            end else begin
                                o_cmd.out_load = 1'b1;
                            end
                        end
                        lmsp_pkg::FUNC_WRITE: begin
                            o_cmd.pix_wr   = 1'b1;
                            o_cmd.out_load = 1'b1;
                        end
                        lmsp_pkg::FUNC_READ: begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = S_READ;
                        end
                        lmsp_pkg::FUNC_UPDATE: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_COPY;
                        end
                        lmsp_pkg::FUNC_CLEAR: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_load  = 1'b1;
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            S_ADV: begin
                o_cmd.adv     = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state       = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.fetch_last) begin
                    n_state = S_SHOW;
                end
            end
            S_SHOW: begin
                o_cmd.show     = 1'b1;
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            S_COPY: begin
                o_cmd.copy    = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.copy_last) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_back = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                if (i_stat.store_last) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lmsp_dp.sv
`default_nettype none

module lmsp_dp #(
    parameter int COLUMNS    = 17,
    parameter int PWM_LEVELS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lmsp_pkg::t_cmd               i_cmd,
    output lmsp_pkg::t_stat                   o_stat,
    input  wire logic [lmsp_pkg::LVL_W-1:0]   i_col_x,
    input  wire logic [lmsp_pkg::LVL_W-1:0]   i_row_y,
    input  wire logic [lmsp_pkg::LVL_W-1:0]   i_level,
    input  wire logic                         i_cfg_valid,
    input  wire logic [lmsp_pkg::LVL_W-1:0]   i_cfg_data,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic      [lmsp_pkg::LVL_W-1:0]   o_row_drive,
    output logic      [lmsp_pkg::COL_W-1:0]   o_column_drive,
    output logic      [lmsp_pkg::LVL_W-1:0]   o_read_level
);

    localparam int ROWS_N = lmsp_pkg::ROWS;
    localparam int LW     = lmsp_pkg::LVL_W;
    localparam int CDW    = lmsp_pkg::COL_W;
    localparam int DEPTH  = COLUMNS * ROWS_N;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int SW     = (PWM_LEVELS > 1) ? $clog2(PWM_LEVELS) : 1;

    logic [CNT_W-1:0]  r_cnt;
    logic [LW-1:0]     r_timer,    n_timer;
    logic [CW-1:0]     r_col,      n_col;
    logic [SW-1:0]     r_step,     n_step;
    logic [LW-1:0]     r_row_bits, n_row_bits;
    logic [CDW-1:0]    r_col_bits, n_col_bits;
    logic [LW-1:0]     r_bright;
    logic [ROWS_N-1:0] r_lit;
    logic              r_rd_ok;
    logic              r_out_valid;
    logic [LW-1:0]     r_out_row;
    logic [CDW-1:0]    r_out_col;
    logic [LW-1:0]     r_out_rd;

    logic              pix_ok;
    logic [AW-1:0]     pix_addr;
    logic [AW-1:0]     cnt_addr;
    logic [AW-1:0]     fetch_addr;
    logic [LW-1:0]     timer_inc;
    logic [CDW-1:0]    col_onehot;
    logic              bright_mid;
    logic              lit_new;
    logic [LW-1:0]     mask;

    logic              back_we;
    logic [AW-1:0]     back_waddr;
    logic [LW-1:0]     back_wdata;
    logic [AW-1:0]     back_raddr;
    logic [LW-1:0]     back_rdata;
    logic              front_we;
    logic [AW-1:0]     front_waddr;
    logic [LW-1:0]     front_wdata;
    logic [LW-1:0]     front_rdata;

    assign pix_ok     = (i_col_x < LW'(COLUMNS)) && (i_row_y < LW'(ROWS_N));
    assign pix_addr   = AW'(i_col_x) * AW'(ROWS_N) + AW'(i_row_y);
    assign cnt_addr   = r_cnt[AW-1:0];
    assign fetch_addr = AW'(r_col) * AW'(ROWS_N) + AW'(r_cnt);
    assign timer_inc  = r_timer + LW'(1);
    assign col_onehot = CDW'(1) << r_col;
    assign bright_mid = (r_bright >= lmsp_pkg::CMP_LOW) && (r_bright <= lmsp_pkg::CMP_HIGH);
    assign lit_new    = front_rdata > LW'(r_step);

    // row output order, low bit first: rows 4 1 5 4 3 2 1 0
    assign mask = {r_lit[0], r_lit[1], r_lit[2], r_lit[3],
                   r_lit[4], r_lit[5], r_lit[1], r_lit[4]};

    always_comb begin
        n_timer    = r_timer;
        n_col      = r_col;
        n_step     = r_step;
        n_row_bits = r_row_bits;
        n_col_bits = r_col_bits;
        if (i_cmd.tick) begin
            n_timer = timer_inc;
            if (timer_inc == r_bright && bright_mid) begin
                n_col_bits = n_col_bits & ~col_onehot;
            end
        end
        if (i_cmd.adv) begin
            if (r_bright > lmsp_pkg::CMP_HIGH) begin
                n_col_bits = n_col_bits & ~col_onehot;
            end
            if (r_col == CW'(COLUMNS - 1)) begin
                n_col  = '0;
                n_step = (r_step == SW'(PWM_LEVELS - 1)) ? '0 : r_step + SW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        if (i_cmd.show) begin
            n_row_bits = mask;
            if (mask != '0) begin
                n_col_bits = n_col_bits | col_onehot;
            end
            // very low brightness: the column enable is cancelled in the same update, so it stays off
            if (r_bright < lmsp_pkg::CMP_LOW) begin
                n_col_bits = n_col_bits & ~col_onehot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_timer     <= '0;
            r_col       <= '0;
            r_step      <= '0;
            r_row_bits  <= '0;
            r_col_bits  <= '0;
            r_bright    <= lmsp_pkg::BRIGHT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_timer    <= n_timer;
            r_col      <= n_col;
            r_step     <= n_step;
            r_row_bits <= n_row_bits;
            r_col_bits <= n_col_bits;
            if (i_cfg_valid) begin
                r_bright <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_req) begin
            r_rd_ok <= pix_ok;
        end
        // RAM read is registered, so read data lags the address; the first fetch step carries none
        if (i_cmd.fetch && r_cnt != '0) begin
            r_lit <= {lit_new, r_lit[ROWS_N-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out_row <= n_row_bits;
            r_out_col <= n_col_bits;
            r_out_rd  <= (i_cmd.rd_load && r_rd_ok) ? back_rdata : '0;
        end
    end

    always_comb begin
        back_we    = i_cmd.mem_zero | i_cmd.clear_back | (i_cmd.pix_wr & pix_ok);
        back_waddr = i_cmd.pix_wr ? pix_addr : cnt_addr;
        back_wdata = i_cmd.pix_wr ? i_level : '0;
        back_raddr = i_cmd.copy ? cnt_addr : (pix_ok ? pix_addr : '0);
        front_we    = i_cmd.mem_zero | (i_cmd.copy & (r_cnt != '0));
        front_waddr = i_cmd.mem_zero ? cnt_addr : cnt_addr - AW'(1);
        front_wdata = i_cmd.mem_zero ? '0 : back_rdata;
    end

    lmsp_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (back_waddr),
        .i_wdata (back_wdata),
        .i_raddr (back_raddr),
        .o_rdata (back_rdata)
    );

    lmsp_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (front_we),
        .i_waddr (front_waddr),
        .i_wdata (front_wdata),
        .i_raddr (fetch_addr),
        .o_rdata (front_rdata)
    );

    always_comb begin
        o_stat.wrap       = (timer_inc == '0);
        o_stat.store_last = (r_cnt == CNT_W'(DEPTH - 1));
        o_stat.copy_last  = (r_cnt == CNT_W'(DEPTH));
        o_stat.fetch_last = (r_cnt == CNT_W'(ROWS_N));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_drive    = r_out_row;
    assign o_column_drive = r_out_col;
    assign o_read_level   = r_out_rd;

endmodule

`default_nettype wire
